FILE: hdl/nprd_pkg.sv
// ----------------------------------------------------------------------------
// nprd_pkg
// Shared types and constants of the Netpbm raster sample decoder.
// ----------------------------------------------------------------------------
package nprd_pkg;

   // Kind of work the front hands to the back
   typedef enum logic [1:0] {
      KIND_BITMAP,
      KIND_PASS,
      KIND_DIVIDE
   } kind_type;

   // Queue entry: numerator holds the raw byte for bitmap and pass entries
   typedef struct packed {
      kind_type    kind;
      logic [15:0] numer;
      logic [8:0]  divisor;
   } entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_EMIT,
      BK_UNPACK
   } back_state_type;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_BITMAP_MODE       = 3'd0;
   localparam logic [2:0] REG_MAX_VALUE         = 3'd1;
   localparam logic [2:0] REG_IMAGE_WIDTH       = 3'd2;
   localparam logic [2:0] REG_IMAGE_HEIGHT      = 3'd3;
   localparam logic [2:0] REG_SAMPLES_PER_PIXEL = 3'd4;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Width of the dimension limit compares (covers a limit of 65536)
   localparam int unsigned LIMIT_W = 17;

   localparam logic [7:0]  SAMPLE_FULL = 8'hFF;
   localparam logic [7:0]  SAMPLE_ZERO = 8'h00;
   localparam logic [15:0] MAXVAL_BYTE = 16'd255;

endpackage

FILE: hdl/nprd_front.sv
// ----------------------------------------------------------------------------
// nprd_front
// Accepts raster bytes, pairs two-byte samples and classifies the work.
// ----------------------------------------------------------------------------
module nprd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_bitmap_mode,
   input  logic [15:0]         cfg_max_value,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   output logic                push_valid,
   input  logic                push_ready,
   output nprd_pkg::entry_type push_entry
);
   import nprd_pkg::*;

   logic        phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] mv_eff;
   logic        wide;
   logic        accept;
   logic [8:0]  wide_div;
   logic [15:0] byte_numer;

   always_comb begin
      mv_eff     = (cfg_max_value == 16'd0) ? 16'd1 : cfg_max_value;
      wide       = mv_eff > MAXVAL_BYTE;
      // (maxval + 128) >> 8, at most 256
      wide_div   = 9'(({1'b0, mv_eff} + 17'd128) >> 8);
      // byte * 255
      byte_numer = {req_data_byte, 8'h00} - {8'h00, req_data_byte};
      req_ready  = push_ready;
      accept     = req_valid && push_ready;

      phase_in           = phase_ff;
      held_in            = held_ff;
      push_valid         = 1'b0;
      push_entry.kind    = KIND_PASS;
      push_entry.numer   = {8'h00, req_data_byte};
      push_entry.divisor = {1'b0, mv_eff[7:0]};

      if (accept) begin
         priority if (cfg_bitmap_mode) begin
            push_entry.kind = KIND_BITMAP;
            push_valid      = 1'b1;
            phase_in        = 1'b0;
         end else if (wide) begin
            if (!phase_ff) begin
               held_in  = req_data_byte;
               phase_in = 1'b1;
            end else begin
               push_entry.kind    = KIND_DIVIDE;
               push_entry.numer   = {held_ff, req_data_byte};
               push_entry.divisor = wide_div;
               push_valid         = 1'b1;
               phase_in           = 1'b0;
            end
         end else if (mv_eff == MAXVAL_BYTE) begin
            push_entry.kind = KIND_PASS;
            push_valid      = 1'b1;
            phase_in        = 1'b0;
         end else begin
            push_entry.kind  = KIND_DIVIDE;
            push_entry.numer = byte_numer;
            push_valid       = 1'b1;
            phase_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

FILE: hdl/nprd_queue.sv
// ----------------------------------------------------------------------------
// nprd_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module nprd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  nprd_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output nprd_pkg::entry_type pop_entry
);
   import nprd_pkg::*;

   localparam int unsigned DEPTH   = 2;
   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push, pop;

   always_comb begin
      push_ready = count_ff != COUNT_W'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_entry  = slot_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/nprd_back.sv
// ----------------------------------------------------------------------------
// nprd_back
// Divides or unpacks queued work, tracks the raster position, drives results.
// ----------------------------------------------------------------------------
module nprd_back #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_bitmap_mode,
   input  logic [12:0]         cfg_image_width,
   input  logic [12:0]         cfg_image_height,
   input  logic [2:0]          cfg_samples_per_pixel,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  nprd_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_sample_value,
   output logic [1:0]          rsp_channel_index,
   output logic [11:0]         rsp_pixel_column,
   output logic [11:0]         rsp_pixel_row,
   output logic                rsp_row_end,
   output logic                rsp_image_end,
   output logic                rsp_run_last
);
   import nprd_pkg::*;

   localparam logic [LIMIT_W-1:0] WIDTH_LIMIT  = LIMIT_W'(MAX_WIDTH);
   localparam logic [LIMIT_W-1:0] HEIGHT_LIMIT = LIMIT_W'(MAX_HEIGHT);
   localparam logic [2:0]         LAST_STEP    = 3'd7;

   back_state_type state_ff, state_in;
   logic [7:0]  work_ff, work_in;
   logic [7:0]  rem_ff, rem_in;
   logic [8:0]  div_ff, div_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [11:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;
   logic [1:0]  chan_ff, chan_in;
   logic        done_ff, done_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  value_ff, value_in;
   logic [1:0]  chan_out_ff, chan_out_in;
   logic [11:0] col_out_ff, col_out_in;
   logic [11:0] row_out_ff, row_out_in;
   logic        row_end_ff, row_end_in;
   logic        image_end_ff, image_end_in;
   logic        run_last_ff, run_last_in;

   logic [12:0]        wz, hz;
   logic [LIMIT_W-1:0] eff_w, eff_h;
   logic [2:0]         chans;
   logic               last_chan, last_col, last_row;
   logic               out_free, out_load;
   logic [7:0]         emit_value;
   logic               emit_last;
   logic [8:0]         trial;
   logic               fits;

   always_comb begin
      wz    = (cfg_image_width == 13'd0) ? 13'd1 : cfg_image_width;
      hz    = (cfg_image_height == 13'd0) ? 13'd1 : cfg_image_height;
      eff_w = (LIMIT_W'(wz) > WIDTH_LIMIT) ? WIDTH_LIMIT : LIMIT_W'(wz);
      eff_h = (LIMIT_W'(hz) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : LIMIT_W'(hz);
      priority if (cfg_bitmap_mode)              chans = 3'd1;
      else if (cfg_samples_per_pixel == 3'd0)    chans = 3'd1;
      else if (cfg_samples_per_pixel > 3'd4)     chans = 3'd4;
      else                                       chans = cfg_samples_per_pixel;

      last_chan = ({1'b0, chan_ff} + 3'd1) >= chans;
      last_col  = (LIMIT_W'(col_ff) + LIMIT_W'(1)) >= eff_w;
      last_row  = (LIMIT_W'(row_ff) + LIMIT_W'(1)) >= eff_h;
      out_free  = !rsp_valid_ff || rsp_ready;

      // one restoring step: remainder stays below the divisor
      trial = {rem_ff, work_ff[7]};
      fits  = trial >= div_ff;

      state_in   = state_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      chan_in    = chan_ff;
      done_in    = done_ff;
      pop_ready  = 1'b0;
      out_load   = 1'b0;
      emit_value = work_ff;
      emit_last  = 1'b1;

      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            // after the image every entry is dropped
            if (pop_valid && !done_ff) begin
               unique case (pop_entry.kind)
                  KIND_BITMAP: begin
                     work_in  = pop_entry.numer[7:0];
                     cnt_in   = '0;
                     state_in = BK_UNPACK;
                  end
                  KIND_PASS: begin
                     work_in  = pop_entry.numer[7:0];
                     state_in = BK_EMIT;
                  end
                  KIND_DIVIDE: begin
                     if ({1'b0, pop_entry.numer} >= {pop_entry.divisor, 8'h00}) begin
                        work_in  = SAMPLE_FULL;
                        state_in = BK_EMIT;
                     end else begin
                        rem_in   = pop_entry.numer[15:8];
                        work_in  = pop_entry.numer[7:0];
                        div_in   = pop_entry.divisor;
                        cnt_in   = '0;
                        state_in = BK_DIVIDE;
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_DIVIDE: begin
            rem_in  = fits ? 8'(trial - div_ff) : trial[7:0];
            work_in = {work_ff[6:0], fits};
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff == LAST_STEP) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_UNPACK: begin
            emit_value = work_ff[7] ? SAMPLE_ZERO : SAMPLE_FULL;
            emit_last  = last_col || (cnt_ff == LAST_STEP);
            if (out_free) begin
               out_load = 1'b1;
               work_in  = {work_ff[6:0], 1'b0};
               cnt_in   = cnt_ff + 3'd1;
               if (emit_last) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      value_in     = value_ff;
      chan_out_in  = chan_out_ff;
      col_out_in   = col_out_ff;
      row_out_in   = row_out_ff;
      row_end_in   = row_end_ff;
      image_end_in = image_end_ff;
      run_last_in  = run_last_ff;

      if (out_load) begin
         rsp_valid_in = 1'b1;
         value_in     = emit_value;
         chan_out_in  = chan_ff;
         col_out_in   = col_ff;
         row_out_in   = row_ff;
         row_end_in   = last_chan && last_col;
         image_end_in = last_chan && last_col && last_row;
         run_last_in  = emit_last;
         // advance channel, then column, then row
         if (!last_chan) begin
            chan_in = chan_ff + 2'd1;
         end else begin
            chan_in = '0;
            if (!last_col) begin
               col_in = col_ff + 12'd1;
            end else begin
               col_in = '0;
               if (!last_row) begin
                  row_in = row_ff + 12'd1;
               end else begin
                  row_in  = '0;
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         chan_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         chan_ff      <= chan_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      cnt_ff       <= cnt_in;
      value_ff     <= value_in;
      chan_out_ff  <= chan_out_in;
      col_out_ff   <= col_out_in;
      row_out_ff   <= row_out_in;
      row_end_ff   <= row_end_in;
      image_end_ff <= image_end_in;
      run_last_ff  <= run_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_value  = value_ff;
   assign rsp_channel_index = chan_out_ff;
   assign rsp_pixel_column  = col_out_ff;
   assign rsp_pixel_row     = row_out_ff;
   assign rsp_row_end       = row_end_ff;
   assign rsp_image_end     = image_end_ff;
   assign rsp_run_last      = run_last_ff;

   // nothing is produced once the image is complete
   a_no_result_after_image: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !out_load)
      else $error("result produced after image end");

   // image end closes its row and its byte
   a_image_end_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && image_end_ff) |-> (row_end_ff && run_last_ff))
      else $error("image end without row end or run end");

   // divider remainder never reaches the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE) |-> ({1'b0, rem_ff} < div_ff))
      else $error("divider remainder out of range");

endmodule

FILE: hdl/netpbm_raster_sample_decoder.sv
// A byte passes through the front, a queue slot, the back's work register and the
// output register; a scaled sample also runs through the 8-step restoring divider,
// one quotient bit a cycle. The back takes a new queue entry only once it has
// emitted the last sample of the previous one. A bitmap byte gives one sample per
// bit up to the row end; the high byte of a two-byte sample makes no queue entry.
// Reset (synchronous): registers to defaults, position and image-done cleared.
// ----------------------------------------------------------------------------
// netpbm_raster_sample_decoder
// Decodes Netpbm raster bytes into 8-bit samples tagged with raster position.
// ----------------------------------------------------------------------------
module netpbm_raster_sample_decoder #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // raster byte input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   // sample output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_sample_value,
   output logic [1:0]                        rsp_channel_index,
   output logic [11:0]                       rsp_pixel_column,
   output logic [11:0]                       rsp_pixel_row,
   output logic                              rsp_row_end,
   output logic                              rsp_image_end,
   output logic                              rsp_run_last,
   // CSR port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nprd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nprd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nprd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import nprd_pkg::*;

   // Configuration registers
   logic        bitmap_mode_ff;
   logic [15:0] max_value_ff;
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;
   logic [2:0]  samples_per_pixel_ff;

   logic        csr_write;
   logic [2:0]  csr_index;

   // Front-to-queue and queue-to-back links
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // Registers sit at byte address 4*index; word offset bits are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_BITMAP_MODE:       prdata = CSR_DATA_W'(bitmap_mode_ff);
         REG_MAX_VALUE:         prdata = CSR_DATA_W'(max_value_ff);
         REG_IMAGE_WIDTH:       prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT:      prdata = CSR_DATA_W'(image_height_ff);
         REG_SAMPLES_PER_PIXEL: prdata = CSR_DATA_W'(samples_per_pixel_ff);
         default:               prdata = '0;
      endcase
   end

   // Writes outside the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_mode_ff       <= 1'b0;
         max_value_ff         <= 16'd255;
         image_width_ff       <= 13'd1;
         image_height_ff      <= 13'd1;
         samples_per_pixel_ff <= 3'd1;
      end else if (csr_write && pready) begin
         unique case (csr_index)
            REG_BITMAP_MODE:       bitmap_mode_ff       <= pwdata[0];
            REG_MAX_VALUE:         max_value_ff         <= pwdata[15:0];
            REG_IMAGE_WIDTH:       image_width_ff       <= pwdata[12:0];
            REG_IMAGE_HEIGHT:      image_height_ff      <= pwdata[12:0];
            REG_SAMPLES_PER_PIXEL: samples_per_pixel_ff <= pwdata[2:0];
            default:               bitmap_mode_ff       <= bitmap_mode_ff;
         endcase
      end
   end

   // Front: takes one byte per cycle while the queue has room. Holds the
   // high byte of a two-byte sample and forms numerator and divisor.
   nprd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg_bitmap_mode (bitmap_mode_ff),
      .cfg_max_value   (max_value_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_entry      (push_entry)
   );

   // Short queue so the front keeps taking bytes while the back divides.
   nprd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back: divider / bitmap unpacker, position counters and the output register.
   // Samples scaling above 255 saturate; bytes after the image are dropped.
   nprd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg_bitmap_mode       (bitmap_mode_ff),
      .cfg_image_width       (image_width_ff),
      .cfg_image_height      (image_height_ff),
      .cfg_samples_per_pixel (samples_per_pixel_ff),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_entry             (pop_entry),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_sample_value      (rsp_sample_value),
      .rsp_channel_index     (rsp_channel_index),
      .rsp_pixel_column      (rsp_pixel_column),
      .rsp_pixel_row         (rsp_pixel_row),
      .rsp_row_end           (rsp_row_end),
      .rsp_image_end         (rsp_image_end),
      .rsp_run_last          (rsp_run_last)
   );

endmodule
